### hdl/mdk_pkg.sv
// Package for the Morse digit keyer: job descriptor type, character
// constants, digit pattern table and queue sizing. No dependencies.
`default_nettype none

package mdk_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned DurW   = 18;
  localparam int unsigned CharW  = 8;
  localparam int unsigned PatW   = 5;
  localparam int unsigned ElemW  = 3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] CharZero = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharNine = 8'h39;  // '9'
  localparam logic [CharW-1:0] CharE    = 8'h45;  // 'E'

  localparam logic [ElemW-1:0] ElemsDigit  = 3'd5;
  localparam logic [ElemW-1:0] ElemsLetter = 3'd1;
  localparam logic [ElemW-1:0] ElemsNone   = 3'd0;

  localparam logic [UnitW-1:0] UnitReset = 16'd4;
  localparam logic [UnitW-1:0] UnitMin   = 16'd1;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [0:0]  RegUnitLength = 1'b0;

  // One character as the back end needs it: element count and dash mask,
  // first element in the MSB.
  typedef struct packed {
    logic [ElemW-1:0] elems;
    logic [PatW-1:0]  pattern;
  } mdk_job_t;

  function automatic logic [PatW-1:0] digit_pattern(input logic [3:0] digit);
    logic [PatW-1:0] pat;
    case (digit)
      4'd0:    pat = 5'h1F;
      4'd1:    pat = 5'h0F;
      4'd2:    pat = 5'h07;
      4'd3:    pat = 5'h03;
      4'd4:    pat = 5'h01;
      4'd5:    pat = 5'h00;
      4'd6:    pat = 5'h10;
      4'd7:    pat = 5'h18;
      4'd8:    pat = 5'h1C;
      4'd9:    pat = 5'h1E;
      default: pat = 5'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### hdl/morse_digit_keyer.sv
// Morse digit keyer top level: APB unit-length register, front end, job
// queue and back end. Depends on mdk_pkg, mdk_front, mdk_queue, mdk_back.
// Path: request -> queue -> back-end job registers -> output register.
// Throughput: one segment per cycle from the single output register
//   while out_ready_i allows; a digit is 11 segments, 'E' 3, others 1.
// Reset: unit_length returns to 4, queue and outputs empty.
`default_nettype none

module morse_digit_keyer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mdk_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [mdk_pkg::ApbDataW-1:0] pwdata,
  output logic      [mdk_pkg::ApbDataW-1:0] prdata,
  output logic                              pready,
  input  wire logic [mdk_pkg::CharW-1:0]    char_code_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              key_level_o,
  output logic [mdk_pkg::DurW-1:0]          duration_ticks_o,
  output logic                              last_segment_o
);
  import mdk_pkg::*;

  logic [UnitW-1:0] unit_q, unit_eff;
  logic             reg_hit;
  logic             push, q_ready, q_valid, pop;
  mdk_job_t         wr_job, rd_job;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ApbAddrW-1:2] == RegUnitLength);
  assign prdata  = reg_hit ? ApbDataW'(unit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UnitReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      unit_q <= pwdata[UnitW-1:0];
    end
  end

  // A zero unit keys as one tick
  assign unit_eff = (unit_q == '0) ? UnitMin : unit_q;

  mdk_front u_front (
    .char_code_i (char_code_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .job_o       (wr_job),
    .q_ready_i   (q_ready)
  );

  mdk_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_job_i (wr_job),
    .ready_o  (q_ready),
    .pop_i    (pop),
    .rd_job_o (rd_job),
    .valid_o  (q_valid)
  );

  mdk_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .unit_i           (unit_eff),
    .job_i            (rd_job),
    .job_valid_i      (q_valid),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_level_o      (key_level_o),
    .duration_ticks_o (duration_ticks_o),
    .last_segment_o   (last_segment_o)
  );

endmodule

`default_nettype wire

### hdl/mdk_front.sv
// Front end: takes character requests and classifies them into job
// descriptors for the queue. Depends on mdk_pkg.
`default_nettype none

module mdk_front (
  input  wire logic [mdk_pkg::CharW-1:0] char_code_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  output logic                           push_o,
  output mdk_pkg::mdk_job_t              job_o,
  input  wire logic                      q_ready_i
);
  import mdk_pkg::*;

  logic            is_digit;
  logic [CharW-1:0] offset;

  assign offset   = char_code_i - CharZero;
  assign is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);

  always_comb begin
    if (is_digit) begin
      job_o.elems   = ElemsDigit;
      job_o.pattern = digit_pattern(offset[3:0]);
    end else if (char_code_i == CharE) begin
      job_o.elems   = ElemsLetter;
      job_o.pattern = '0;
    end else begin
      job_o.elems   = ElemsNone;
      job_o.pattern = '0;
    end
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

endmodule

`default_nettype wire

### hdl/mdk_queue.sv
// Short job queue between front and back end, register based.
// Depends on mdk_pkg.
`default_nettype none

module mdk_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire mdk_pkg::mdk_job_t  wr_job_i,
  output logic                    ready_o,
  input  wire logic               pop_i,
  output mdk_pkg::mdk_job_t       rd_job_o,
  output logic                    valid_o
);
  import mdk_pkg::*;

  mdk_job_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o  = (cnt_q != QCntW'(QDepth));
  assign valid_o  = (cnt_q != '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wr_job_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/mdk_back.sv
// Back end (uses mdk_pkg): steps through each job's elements and puts
// a keying segment per cycle in an output register; out_ready_i stalls.
`default_nettype none

module mdk_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [mdk_pkg::UnitW-1:0] unit_i,
  input  wire mdk_pkg::mdk_job_t         job_i,
  input  wire logic                      job_valid_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           key_level_o,
  output logic [mdk_pkg::DurW-1:0]       duration_ticks_o,
  output logic                           last_segment_o
);
  import mdk_pkg::*;

  logic             active_q;
  logic [ElemW-1:0] elems_q;
  logic [PatW-1:0]  pat_q;
  logic             off_phase_q;  // 1: the gap after the current element

  logic             oval_q;
  logic             level_q, last_q;
  logic [DurW-1:0]  dur_q;

  logic             adv, final_seg, load;
  logic [DurW-1:0]  dur_one, dur_two, dur_three;
  logic             seg_level;
  logic [DurW-1:0]  seg_dur;

  assign dur_one   = DurW'(unit_i);
  assign dur_two   = {dur_one[DurW-2:0], 1'b0};
  assign dur_three = dur_one + dur_two;

  assign adv       = active_q && (!oval_q || out_ready_i);
  assign final_seg = (elems_q == '0);
  assign load      = job_valid_i && (!active_q || (adv && final_seg));
  assign pop_o     = load;

  always_comb begin
    if (final_seg) begin
      seg_level = 1'b0;
      seg_dur   = dur_two;
    end else if (!off_phase_q) begin
      seg_level = 1'b1;
      seg_dur   = pat_q[PatW-1] ? dur_three : dur_one;
    end else begin
      seg_level = 1'b0;
      seg_dur   = dur_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      elems_q     <= '0;
      pat_q       <= '0;
      off_phase_q <= 1'b0;
      oval_q      <= 1'b0;
    end else begin
      if (load) begin
        active_q    <= 1'b1;
        elems_q     <= job_i.elems;
        pat_q       <= job_i.pattern;
        off_phase_q <= 1'b0;
      end else if (adv) begin
        if (final_seg) begin
          active_q <= 1'b0;
        end else if (!off_phase_q) begin
          off_phase_q <= 1'b1;
        end else begin
          off_phase_q <= 1'b0;
          elems_q     <= elems_q - 1'b1;
          pat_q       <= {pat_q[PatW-2:0], 1'b0};
        end
      end
      if (adv) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      level_q <= seg_level;
      dur_q   <= seg_dur;
      last_q  <= final_seg;
    end
  end

  assign out_valid_o      = oval_q;
  assign key_level_o      = level_q;
  assign duration_ticks_o = dur_q;
  assign last_segment_o   = last_q;

  a_gap_is_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && last_q |-> !level_q)
    else $error("final gap keyed on");

  a_on_then_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && out_ready_i && level_q |=> !(oval_q && level_q))
    else $error("two on segments in a row");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && active_q |-> adv && final_seg)
    else $error("job loaded over a running job");

endmodule

`default_nettype wire
